/* design/fla_pkg.sv */
// shared types and constants for the free list node allocator
// used by fla_ctrl, fla_dp and free_list_node_allocator
package fla_pkg;

   localparam int MAX_NODES = 1024;
   localparam int ID_SPACE  = 1024;
   localparam int ID_W      = 10;
   localparam int LINK_W    = 11;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int TDATA_W   = 16;
   localparam int TUSER_W   = 2;

   localparam int POOL_LIMIT_INT = (MAX_NODES < ID_SPACE) ? MAX_NODES : ID_SPACE;
   localparam logic [LINK_W-1:0] POOL_LIMIT = LINK_W'(POOL_LIMIT_INT);
   localparam logic [LINK_W-1:0] LINK_NULL  = '1;

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic accept;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_read;
   } dp_sts_type;

endpackage

/* design/fla_ctrl.sv */
// controller for the free list node allocator: handshakes and pop sequencing
// depends on fla_pkg
module fla_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  fla_pkg::dp_sts_type sts,
   output fla_pkg::dp_cmd_type cmd
);
   import fla_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic load;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.finish = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && slot_free) begin
               cmd.accept = 1'b1;
               if (sts.needs_read) begin
                  state_in = S_POP;
               end else begin
                  load = 1'b1;
               end
            end
         end
         S_POP: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               load       = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/fla_dp.sv */
// datapath for the free list node allocator: link memory, head, count, result
// depends on fla_pkg
module fla_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fla_pkg::OP_W-1:0]      op,
   input  logic [fla_pkg::ID_W-1:0]      node_id,
   input  fla_pkg::dp_cmd_type           cmd,
   output fla_pkg::dp_sts_type           sts,
   output logic [fla_pkg::ID_W-1:0]      result_id,
   output logic [fla_pkg::STATUS_W-1:0]  status
);
   import fla_pkg::*;

   logic [LINK_W-1:0] link_mem [ID_SPACE];
   logic [LINK_W-1:0] rd_data_ff;

   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   count_ff, count_in;
   logic [ID_W-1:0]     pop_id_ff, pop_id_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;

   logic              mem_we;
   logic              mem_re;
   logic [ID_W-1:0]   mem_addr;
   logic [LINK_W-1:0] mem_wdata;
   logic              in_range;
   logic              head_null;

   assign head_null      = (head_ff == LINK_NULL);
   assign in_range       = {1'b0, node_id} < count_ff;
   assign sts.needs_read = (op == OP_ALLOC) && !head_null;
   assign result_id      = res_id_ff;
   assign status         = res_st_ff;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      pop_id_in = pop_id_ff;
      res_id_in = res_id_ff;
      res_st_in = res_st_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = head_ff[ID_W-1:0];
      mem_wdata = LINK_NULL;
      if (cmd.accept) begin
         case (op)
            OP_ALLOC: begin
               if (!head_null) begin
                  mem_re    = 1'b1;
                  pop_id_in = head_ff[ID_W-1:0];
               end else if (count_ff >= POOL_LIMIT) begin
                  res_id_in = '0;
                  res_st_in = ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_addr  = count_ff[ID_W-1:0];
                  mem_wdata = LINK_NULL;
                  count_in  = count_ff + LINK_W'(1);
                  res_id_in = count_ff[ID_W-1:0];
                  res_st_in = ST_OK;
               end
            end
            OP_FREE: begin
               res_id_in = node_id;
               if (in_range) begin
                  mem_we    = 1'b1;
                  mem_addr  = node_id;
                  mem_wdata = head_ff;
                  head_in   = {1'b0, node_id};
                  res_st_in = ST_OK;
               end else begin
                  res_st_in = ST_RANGE;
               end
            end
            OP_LOOKUP: begin
               res_id_in = node_id;
               res_st_in = in_range ? ST_OK : ST_RANGE;
            end
            default: begin
               res_id_in = node_id;
               res_st_in = in_range ? ST_OK : ST_RANGE;
            end
         endcase
      end else if (cmd.finish) begin
         head_in   = rd_data_ff;
         res_id_in = pop_id_ff;
         res_st_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= link_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= LINK_NULL;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_id_ff <= pop_id_in;
      res_id_ff <= res_id_in;
      res_st_ff <= res_st_in;
   end

endmodule

/* design/free_list_node_allocator.sv */
// top level of the free list node allocator
// depends on fla_pkg, fla_ctrl and fla_dp
//
//   channel  dir  payload
//   req_     in   tuser: op[1:0]; tdata: node_id[9:0], zero filled to 16 bits
//   rsp_     out  tuser: status[1:0]; tdata: result_id[9:0], zero filled to 16 bits
//
// an allocate that pops a freed node passes through the pop state: the link of the head is
// read from the synchronous link memory before the head is updated
// free, lookup and an allocate of a fresh node load the result on acceptance, with no pop state
// the result register lets a new request in while it is drained in the same cycle
// synchronous active high reset empties the free list and the node count
module free_list_node_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // node_id[9:0], zeros
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_id[9:0], zeros
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import fla_pkg::*;

   dp_cmd_type          cmd;
   dp_sts_type          sts;
   logic [ID_W-1:0]     result_id;
   logic [STATUS_W-1:0] status;

   fla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fla_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (req_tuser[OP_W-1:0]),
      .node_id   (req_tdata[ID_W-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .result_id (result_id),
      .status    (status)
   );

   assign rsp_tdata = {{(TDATA_W-ID_W){1'b0}}, result_id};
   assign rsp_tuser = status;

endmodule
